// ===== sv/wavetable_fm_oscillator_defines.svh =====
// Assertion macros for the wavetable FM oscillator.
// Included by files that check their own sequencing; needs clk and rst in scope.
`ifndef WAVETABLE_FM_OSCILLATOR_DEFINES_SVH
`define WAVETABLE_FM_OSCILLATOR_DEFINES_SVH

// Condition and consequence in the same cycle.
`define WFO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define WFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wfo_pkg.sv =====
// Shared types, constants and helper functions of the wavetable FM oscillator.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package wfo_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int INC_W     = 27;
  localparam int INDEX_W   = 11;
  localparam int SHIFT_W   = 4;
  localparam int RAMP_W    = 13;
  localparam int AMP_W     = 32;
  localparam int MUL_A_W   = INC_W + 1;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [INC_W-1:0]           inc_t;
  typedef logic [INDEX_W-1:0]         table_index_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_index_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_INCREMENT_TARGET = 3'd0;
  localparam cfg_index_t REG_AMPLITUDE_TARGET = 3'd1;
  localparam cfg_index_t REG_PHASE_OFFSET     = 3'd2;
  localparam cfg_index_t REG_RAMP_SHIFT       = 3'd3;
  localparam cfg_index_t REG_TABLE_PRESENT    = 3'd4;

  // Item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [SHIFT_W-1:0] MAX_RAMP_SHIFT   = 4'd12;
  localparam logic [SHIFT_W-1:0] RAMP_SHIFT_RESET = 4'd6;
  localparam inc_t               INC_MAX          = '1;
  localparam sample_t            SAMPLE_MAX       = 16'sh7FFF;
  localparam sample_t            SAMPLE_MIN       = -16'sh8000;

  // Arithmetic shift right that rounds toward zero.
  function automatic logic signed [32:0] trunc_shr(input logic signed [32:0] v,
                                                   input logic [SHIFT_W-1:0] sh);
    logic [32:0] mag;
    logic [32:0] res;
    mag = v[32] ? 33'(-v) : 33'(v);
    res = mag >> sh;
    return v[32] ? -$signed(res) : $signed(res);
  endfunction

endpackage

`default_nettype wire

// ===== sv/wfo_in_if.sv =====
// Input channel of the oscillator: sample ticks and wave table writes.
// Uses wfo_pkg for the payload types.
`default_nettype none

interface wfo_in_if;
  import wfo_pkg::*;

  logic         valid;
  logic         ready;
  logic         kind;
  sample_t      fm_sample;
  logic         fm_present;
  table_index_t table_index;
  sample_t      table_value;

  modport source (output valid, kind, fm_sample, fm_present, table_index, table_value,
                  input ready);
  modport sink   (input valid, kind, fm_sample, fm_present, table_index, table_value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/wfo_out_if.sv =====
// Output channel of the oscillator: one output sample per tick.
// Uses wfo_pkg for the payload type.
`default_nettype none

interface wfo_out_if;
  import wfo_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

// ===== sv/wavetable_fm_oscillator.sv =====
// Wavetable oscillator with linear interpolation, FM and linear parameter ramps.
// Depends on wfo_pkg, wfo_in_if, wfo_out_if, wfo_mul, wfo_table and the defines header.
//
// Channel   Dir   Transaction
// items     in    tick (kind 0) or wave table word write (kind 1)
// results   out   one saturated Q1.15 sample per tick
// cfg_*     in    register write, one per cycle with cfg_we high
//
// A tick with a table loaded steps through RD1, RD2, MUL1, VAL, MUL2, MUL3, PHASE
// and EMIT before the next acceptance: two table reads through the single read port
// and three products through the one shared multiplier, each a step of the sequencer.
// A tick without a table goes straight to EMIT; a table write leaves the sequencer in IDLE.
// Synchronous reset clears the sequencer, phase and ramps; no clearing pass.
// A finished sample waits in the output register; the sequencer stalls only
// when a second sample is ready before the first was taken.
`default_nettype none
`include "wavetable_fm_oscillator_defines.svh"

module wavetable_fm_oscillator #(
  parameter int TABLE_BITS          = 11,
  parameter int PHASE_FRACTION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire wfo_pkg::cfg_index_t cfg_index,
  input  wire wfo_pkg::cfg_data_t  cfg_data,
  wfo_in_if.sink                   items,
  wfo_out_if.source                results
);
  import wfo_pkg::*;

  localparam int PW        = TABLE_BITS + PHASE_FRACTION_BITS;
  localparam int SUM_W     = ((PW > INC_W) ? PW : INC_W) + 1;
  localparam int IDX_EXT_W = (TABLE_BITS > INDEX_W) ? TABLE_BITS : INDEX_W;
  localparam int MUL_B_W   = (PHASE_FRACTION_BITS + 1 > 17) ? PHASE_FRACTION_BITS + 1 : 17;
  localparam int P_W       = MUL_A_W + MUL_B_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_MUL1, S_VAL, S_MUL2, S_MUL3, S_PHASE, S_EMIT
  } state_t;

  // Configuration registers.
  inc_t               increment_target;
  sample_t            amplitude_target;
  inc_t               phase_offset;
  logic [SHIFT_W-1:0] ramp_shift;
  logic               table_present;

  // Oscillator state.
  state_t                  state;
  logic [PW-1:0]           phase;
  inc_t                    inc_now;
  logic signed [INC_W:0]   inc_step;
  logic [RAMP_W-1:0]       inc_left;
  inc_t                    inc_seen;
  logic signed [AMP_W-1:0] amp_now;
  logic signed [AMP_W-1:0] amp_step;
  logic [RAMP_W-1:0]       amp_left;
  sample_t                 amp_seen;
  logic                    out_valid;

  // Datapath registers.
  logic [PW-1:0] pos;
  sample_t       fm;
  logic          fm_on;
  sample_t       v1;
  sample_t       val;
  sample_t       res;
  sample_t       out_sample;

  // Handshake and helper signals.
  logic                      accept;
  logic                      slot_free;
  logic [SUM_W-1:0]          pos_sum;
  logic [SUM_W-1:0]          phase_sum;
  inc_t                      delta;
  logic [P_W-1:0]            dq;
  logic [TABLE_BITS-1:0]     idx;
  logic [PHASE_FRACTION_BITS-1:0] frac;
  logic [IDX_EXT_W-1:0]      widx_ext;
  logic [TABLE_BITS-1:0]     raddr;
  sample_t                   rdata;
  logic [SHIFT_W-1:0]        sh_eff;
  logic [RAMP_W-1:0]         ramp_len;
  logic signed [32:0]        inc_diff;
  logic signed [32:0]        amp_diff;
  logic signed [32:0]        inc_shr;
  logic signed [32:0]        amp_shr;
  logic [INC_W:0]            inc_sum;
  logic signed [16:0]        wave_diff;
  logic signed [16:0]        fm_off;
  logic signed [P_W-1:0]     interp_shr;
  logic signed [P_W-1:0]     interp_sum;
  logic signed [P_W-1:0]     gain_shr;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]     mul_p;

  assign accept        = items.valid && items.ready;
  assign items.ready   = (state == S_IDLE);
  assign slot_free     = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.sample = out_sample;

  // Phase split into table index and interpolation fraction.
  assign pos_sum = SUM_W'(phase) + SUM_W'(phase_offset);
  assign idx     = pos[PW-1:PHASE_FRACTION_BITS];
  assign frac    = pos[PHASE_FRACTION_BITS-1:0];

  // Table write address, taken modulo the table size.
  assign widx_ext = IDX_EXT_W'(items.table_index);
  assign raddr    = (state == S_RD2) ? idx + 1'b1 : idx;

  wfo_table #(.ADDR_W(TABLE_BITS)) u_table (
    .clk   (clk),
    .we    (accept && items.kind == KIND_WRITE),
    .waddr (widx_ext[TABLE_BITS-1:0]),
    .wdata (items.table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Ramp start: new step from the distance to the target.
  assign sh_eff   = (ramp_shift > MAX_RAMP_SHIFT) ? MAX_RAMP_SHIFT : ramp_shift;
  assign ramp_len = RAMP_W'(1) << sh_eff;
  assign inc_diff = $signed({6'b0, increment_target}) - $signed({6'b0, inc_now});
  assign amp_diff = $signed({amplitude_target[SAMPLE_W-1], amplitude_target, 16'b0})
                  - $signed({amp_now[AMP_W-1], amp_now});
  assign inc_shr  = trunc_shr(inc_diff, sh_eff);
  assign amp_shr  = trunc_shr(amp_diff, sh_eff);
  assign inc_sum  = {1'b0, inc_now} + inc_step;

  // Operand selection for the shared multiplier.
  assign wave_diff = {rdata[SAMPLE_W-1], rdata} - {v1[SAMPLE_W-1], v1};
  assign fm_off    = {1'b0, ~fm[SAMPLE_W-1], fm[SAMPLE_W-2:0]};

  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'(wave_diff);
    mul_b  = MUL_B_W'($signed({1'b0, frac}));
    case (state)
      S_MUL1: begin
        mul_en = 1'b1;
      end
      S_MUL2: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'($signed(amp_now[AMP_W-1:AMP_W-SAMPLE_W]));
        mul_b  = MUL_B_W'(val);
      end
      S_MUL3: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, inc_now});
        mul_b  = MUL_B_W'(fm_off);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  wfo_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Interpolation, gain scaling and phase step from the product register.
  assign interp_shr = mul_p >>> PHASE_FRACTION_BITS;
  assign interp_sum = interp_shr + P_W'(v1);
  assign gain_shr   = mul_p >>> 15;
  assign dq         = mul_p >> 15;

  always_comb begin
    if (!fm_on) begin
      delta = inc_now;
    end else if (dq > P_W'(INC_MAX)) begin
      delta = INC_MAX;
    end else begin
      delta = dq[INC_W-1:0];
    end
  end

  assign phase_sum = SUM_W'(phase) + SUM_W'(delta);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      increment_target <= '0;
      amplitude_target <= '0;
      phase_offset     <= '0;
      ramp_shift       <= RAMP_SHIFT_RESET;
      table_present    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INCREMENT_TARGET: increment_target <= cfg_data[INC_W-1:0];
        REG_AMPLITUDE_TARGET: amplitude_target <= cfg_data[SAMPLE_W-1:0];
        REG_PHASE_OFFSET:     phase_offset     <= cfg_data[INC_W-1:0];
        REG_RAMP_SHIFT:       ramp_shift       <= cfg_data[SHIFT_W-1:0];
        REG_TABLE_PRESENT:    table_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer with phase, ramp state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      inc_now   <= '0;
      inc_step  <= '0;
      inc_left  <= '0;
      inc_seen  <= '0;
      amp_now   <= '0;
      amp_step  <= '0;
      amp_left  <= '0;
      amp_seen  <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register fills on emit and empties once taken.
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && items.kind == KIND_TICK) begin
            state <= table_present ? S_RD1 : S_EMIT;
          end
        end
        S_RD1: begin
          // Start a new ramp for each target that changed.
          if (increment_target != inc_seen) begin
            inc_seen <= increment_target;
            inc_left <= ramp_len;
            inc_step <= inc_shr[INC_W:0];
          end
          if (amplitude_target != amp_seen) begin
            amp_seen <= amplitude_target;
            amp_left <= ramp_len;
            amp_step <= amp_shr[AMP_W-1:0];
          end
          state <= S_RD2;
        end
        S_RD2: begin
          // Advance both ramps; the last step lands on the target.
          if (amp_left != '0) begin
            amp_left <= amp_left - 1'b1;
            amp_now  <= (amp_left == RAMP_W'(1)) ? {amp_seen, 16'b0} : amp_now + amp_step;
          end
          if (inc_left != '0) begin
            inc_left <= inc_left - 1'b1;
            inc_now  <= (inc_left == RAMP_W'(1)) ? inc_seen : inc_sum[INC_W-1:0];
          end
          state <= S_MUL1;
        end
        S_MUL1:  state <= S_VAL;
        S_VAL:   state <= S_MUL2;
        S_MUL2:  state <= S_MUL3;
        S_MUL3:  state <= S_PHASE;
        S_PHASE: begin
          phase <= phase_sum[PW-1:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pos   <= pos_sum[PW-1:0];
      fm    <= items.fm_sample;
      fm_on <= items.fm_present;
      res   <= '0;
    end
    if (state == S_RD2) begin
      v1 <= rdata;
    end
    if (state == S_VAL) begin
      val <= interp_sum[SAMPLE_W-1:0];
    end
    if (state == S_MUL3) begin
      if (gain_shr > P_W'(SAMPLE_MAX)) begin
        res <= SAMPLE_MAX;
      end else if (gain_shr < P_W'(SAMPLE_MIN)) begin
        res <= SAMPLE_MIN;
      end else begin
        res <= gain_shr[SAMPLE_W-1:0];
      end
    end
    if (state == S_EMIT && slot_free) begin
      out_sample <= res;
    end
  end

  // Sequencing checks.
  `WFO_ASSERT_NEXT(a_tick_starts,
    accept && items.kind == KIND_TICK && table_present, state == S_RD1,
    "tick with table did not start the read sequence")
  `WFO_ASSERT_NEXT(a_write_stays_idle,
    accept && items.kind == KIND_WRITE, state == S_IDLE,
    "table write left the idle state")
  `WFO_ASSERT_NEXT(a_ramp_held,
    state != S_RD1 && state != S_RD2, $stable(inc_left) && $stable(amp_left),
    "ramp counter moved outside the ramp steps")
  `WFO_ASSERT_NEXT(a_emit_sets_valid,
    state == S_EMIT && slot_free, results.valid,
    "finished sample was not presented")

endmodule

`default_nettype wire

// ===== sv/wfo_mul.sv =====
// Shared signed multiplier with a registered product, loaded on enable.
// Standalone; the oscillator sequencer time-shares it for three products.
`default_nettype none

module wfo_mul #(
  parameter int A_W = 28,
  parameter int B_W = 17
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [A_W-1:0]    a,
  input  wire logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0]     p
);

  // Product register holds its value while the unit is not in use.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wfo_table.sv =====
// Wave table memory: one write port and one read port with registered data.
// Uses wfo_pkg for the word type.
`default_nettype none

module wfo_table #(
  parameter int ADDR_W = 11
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   waddr,
  input  wire wfo_pkg::sample_t    wdata,
  input  wire logic [ADDR_W-1:0]   raddr,
  output wfo_pkg::sample_t         rdata
);
  import wfo_pkg::*;

  sample_t mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
